// ===== src/pbfe_pkg.sv =====
package pbfe_pkg;

    // Fraction bits of the length, force and energy words.
    localparam int FRAC_BITS = 16;

    // Field widths.
    localparam int RSQ_W    = 32;
    localparam int SEG_W    = 24;
    localparam int KUHN_W   = 24;
    localparam int FORCE_W  = 32;
    localparam int ENERGY_W = 48;

    // Quotient width of both dividers; lam^2 is kept in Q0.32.
    localparam int QW = 32;

    // Internal widths.
    localparam int P_W     = SEG_W + KUHN_W;
    localparam int PH_W    = P_W / 2;
    localparam int P2_W    = 2 * P_W;
    localparam int C9801_W = P2_W + 14;
    localparam int CMP_W   = C9801_W + 2;
    localparam int R10K_W  = RSQ_W + 14;
    localparam int BB_W    = 2 * KUHN_W;
    localparam int CB_W    = KUHN_W + 15;
    localparam int CB_LO_W = 20;
    localparam int SQ_RW   = (RSQ_W + FRAC_BITS + 1) / 2;
    localparam int SQ_AW   = 2 * SQ_RW;
    localparam int SNUM_W  = RSQ_W + 80 - FRAC_BITS;
    localparam int T_W     = QW + 2;
    localparam int D_W     = QW + 1;
    localparam int DN_W    = D_W + SEG_W;
    localparam int DN_LO_W = DN_W / 2;
    localparam int MD_W    = DN_W + BB_W;
    localparam int CR_W    = CB_W + SQ_RW;
    localparam int MNUM_W  = T_W + FRAC_BITS + 40;
    localparam int Y_W     = QW + 1;
    localparam int K_W     = 6;
    localparam int LNA_W   = QW + K_W;
    localparam int H_W     = LNA_W + 1;
    localparam int H_LO_W  = H_W / 2;
    localparam int EN_W    = SEG_W + H_W;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_CLAMP  = 2'd1,
        ST_FATAL  = 2'd2
    } status_t;

    localparam logic [QW-1:0]  S_CLAMP    = QW'((64'd9801 << QW) / 64'd10000);
    localparam logic [31:0]    LN2_Q32    = 32'd2977044472;
    localparam logic [20:0]    CLAMP_NUM  = 21'd1999701;
    localparam logic [14:0]    CB_MUL     = 15'd19900;
    localparam logic [13:0]    LAM_SQ_NUM = 14'd9801;
    localparam logic [13:0]    LAM_SQ_DEN = 14'd10000;

    typedef struct packed {
        logic                zero;
        status_t             status;
        logic [SEG_W-1:0]    n;
        logic [BB_W-1:0]     bb;
        logic [CB_W-1:0]     cb;
        logic [P2_W-1:0]     p2;
        logic [RSQ_W-1:0]    rsq;
    } sq_side_t;

    typedef struct packed {
        logic                zero;
        status_t             status;
        logic [SEG_W-1:0]    n;
        logic [BB_W-1:0]     bb;
        logic [CB_W-1:0]     cb;
        logic [SQ_RW-1:0]    r;
    } sd_side_t;

    typedef struct packed {
        logic                zero;
        status_t             status;
        logic [SEG_W-1:0]    n;
        logic [QW-1:0]       s;
        logic                ovf;
    } md_side_t;

    typedef struct packed {
        logic                zero;
        status_t             status;
        logic [SEG_W-1:0]    n;
        logic [QW-1:0]       s;
        logic [FORCE_W-1:0]  frc;
        logic [K_W-1:0]      k;
    } lg_side_t;

endpackage

// ===== src/pbfe_sqrt_step.sv =====
module pbfe_sqrt_step #(
    parameter int AW = 48,
    parameter int RW = 24,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [AW-1:0] in_arg,
    input  logic [RW+1:0] in_rem,
    input  logic [RW-1:0] in_res,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [AW-1:0] out_arg,
    output logic [RW+1:0] out_rem,
    output logic [RW-1:0] out_res,
    output logic [SW-1:0] out_side
);

    // One result bit per stage: bring down two argument bits, try 4*res+1.
    logic [RW+3:0] trial_rem;
    logic [RW+3:0] trial_sub;
    logic          fits;

    assign trial_rem = {in_rem, in_arg[AW-1:AW-2]};
    assign trial_sub = (RW+4)'({in_res, 2'b01});
    assign fits      = trial_rem >= trial_sub;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_arg  <= {in_arg[AW-3:0], 2'b00};
            out_rem  <= fits ? (RW+2)'(trial_rem - trial_sub) : (RW+2)'(trial_rem);
            out_res  <= {in_res[RW-2:0], fits};
            out_side <= in_side;
        end
    end

endmodule

// ===== src/pbfe_div_step.sv =====
module pbfe_div_step #(
    parameter int DW = 96,
    parameter int SW = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic [DW-1:0]         in_rem,
    input  logic [pbfe_pkg::QW-1:0] in_nlo,
    input  logic [DW-1:0]         in_den,
    input  logic [pbfe_pkg::QW-1:0] in_q,
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic [DW-1:0]         out_rem,
    output logic [pbfe_pkg::QW-1:0] out_nlo,
    output logic [DW-1:0]         out_den,
    output logic [pbfe_pkg::QW-1:0] out_q,
    output logic [SW-1:0]         out_side
);

    // Restoring division, one quotient bit per stage.
    logic [DW:0] shifted;
    logic [DW:0] den_ext;
    logic        fits;

    assign shifted = {in_rem, in_nlo[pbfe_pkg::QW-1]};
    assign den_ext = {1'b0, in_den};
    assign fits    = shifted >= den_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_rem  <= fits ? DW'(shifted - den_ext) : DW'(shifted);
            out_nlo  <= {in_nlo[pbfe_pkg::QW-2:0], 1'b0};
            out_den  <= in_den;
            out_q    <= {in_q[pbfe_pkg::QW-2:0], fits};
            out_side <= in_side;
        end
    end

endmodule

// ===== src/pbfe_log_step.sv =====
module pbfe_log_step #(
    parameter int SW = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     ce,
    input  logic                     in_valid,
    input  logic [pbfe_pkg::Y_W-1:0] in_y,
    input  logic [pbfe_pkg::QW-1:0]  in_frac,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    output logic [pbfe_pkg::Y_W-1:0] out_y,
    output logic [pbfe_pkg::QW-1:0]  out_frac,
    output logic [SW-1:0]            out_side
);

    // One fraction bit of log2 per stage: square the mantissa and renormalize.
    logic [2*pbfe_pkg::Y_W-1:0] sq;
    logic [pbfe_pkg::Y_W:0]     sq_top;
    logic                       wrap;

    assign sq     = in_y * in_y;
    assign sq_top = sq[2*pbfe_pkg::Y_W-1:pbfe_pkg::QW];
    assign wrap   = sq_top[pbfe_pkg::Y_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_y    <= wrap ? sq_top[pbfe_pkg::Y_W:1] : sq_top[pbfe_pkg::Y_W-1:0];
            out_frac <= {in_frac[pbfe_pkg::QW-2:0], wrap};
            out_side <= in_side;
        end
    end

endmodule

// ===== src/polymer_bond_force_energy.sv =====
// Channel   Direction  Fields                                           Handshake
// s_        in         squared_length, chain_segments, kuhn_length      s_valid / s_ready
// m_        out        force_over_r, energy, status                     m_valid / m_ready
//
// One bond can enter every clock cycle while the pipeline is not frozen. After it is
// accepted it passes through the front end, square root, lam^2 divider, force setup,
// force divider, log normalization, log2 squarings, energy tail and output register.
// Reset clears only the valid bits of the stages; the datapath registers hold junk
// until valid data reaches them. A low m_ready with a full output register freezes the
// whole pipeline, so s_ready is m_ready or an empty output register, and nothing is lost.
module polymer_bond_force_energy (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pbfe_pkg::RSQ_W-1:0]            s_squared_length,
    input  logic [pbfe_pkg::SEG_W-1:0]            s_chain_segments,
    input  logic [pbfe_pkg::KUHN_W-1:0]           s_kuhn_length,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pbfe_pkg::FORCE_W-1:0]   m_force_over_r,
    output logic [pbfe_pkg::ENERGY_W-1:0]         m_energy,
    output logic [1:0]                            m_status
);

    localparam int F      = pbfe_pkg::FRAC_BITS;
    localparam int QW     = pbfe_pkg::QW;
    localparam int PH_W   = pbfe_pkg::PH_W;
    localparam int SQ_SW  = $bits(pbfe_pkg::sq_side_t);
    localparam int SD_SW  = $bits(pbfe_pkg::sd_side_t);
    localparam int MD_SW  = $bits(pbfe_pkg::md_side_t);
    localparam int LG_SW  = $bits(pbfe_pkg::lg_side_t);

    // The whole pipeline advances together whenever the output register can move.
    logic ce;
    logic m_valid_reg;

    assign ce      = m_ready | ~m_valid_reg;
    assign s_ready = ce;
    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Front end: p = N*b, p^2 from partial products, then the two stretch tests.
    // ------------------------------------------------------------------
    logic                             f1_v_reg, f2_v_reg, f3_v_reg, f4_v_reg, f5_v_reg, f6_v_reg;
    logic [pbfe_pkg::RSQ_W-1:0]       f1_rsq_reg, f2_rsq_reg, f3_rsq_reg, f4_rsq_reg, f5_rsq_reg;
    logic [pbfe_pkg::SEG_W-1:0]       f1_n_reg, f2_n_reg, f3_n_reg, f4_n_reg, f5_n_reg;
    logic [pbfe_pkg::KUHN_W-1:0]      f1_b_reg;
    logic [pbfe_pkg::P_W-1:0]         f1_p_reg;
    logic [pbfe_pkg::P_W-1:0]         f2_hh_reg, f2_hl_reg, f2_ll_reg;
    logic [pbfe_pkg::BB_W-1:0]        f2_bb_reg, f3_bb_reg, f4_bb_reg, f5_bb_reg;
    logic [pbfe_pkg::CB_W-1:0]        f2_cb_reg, f3_cb_reg, f4_cb_reg, f5_cb_reg;
    logic [pbfe_pkg::P2_W-1:0]        f3_p2_reg, f4_p2_reg, f5_p2_reg;
    logic [pbfe_pkg::C9801_W-PH_W-1:0] f4_mh_reg;
    logic [pbfe_pkg::C9801_W-PH_W-1:0] f4_ml_reg;
    logic [pbfe_pkg::R10K_W-1:0]      f4_r10k_reg, f5_r10k_reg;
    logic [pbfe_pkg::C9801_W-1:0]     f5_c9801_reg;
    pbfe_pkg::sq_side_t               f6_side_reg;

    logic [pbfe_pkg::CMP_W-1:0] cmp_fatal_lhs, cmp_fatal_rhs, cmp_clamp_lhs, cmp_clamp_rhs;
    pbfe_pkg::status_t          f5_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
            f5_v_reg <= 1'b0;
            f6_v_reg <= 1'b0;
        end else if (ce) begin
            f1_v_reg <= s_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
            f5_v_reg <= f4_v_reg;
            f6_v_reg <= f5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_rsq_reg <= s_squared_length;
            f1_n_reg   <= s_chain_segments;
            f1_b_reg   <= s_kuhn_length;
            f1_p_reg   <= s_chain_segments * s_kuhn_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f2_rsq_reg <= f1_rsq_reg;
            f2_n_reg   <= f1_n_reg;
            f2_hh_reg  <= f1_p_reg[pbfe_pkg::P_W-1:PH_W] * f1_p_reg[pbfe_pkg::P_W-1:PH_W];
            f2_hl_reg  <= f1_p_reg[pbfe_pkg::P_W-1:PH_W] * f1_p_reg[PH_W-1:0];
            f2_ll_reg  <= f1_p_reg[PH_W-1:0] * f1_p_reg[PH_W-1:0];
            f2_bb_reg  <= f1_b_reg * f1_b_reg;
            f2_cb_reg  <= f1_b_reg * pbfe_pkg::CB_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f3_rsq_reg <= f2_rsq_reg;
            f3_n_reg   <= f2_n_reg;
            f3_bb_reg  <= f2_bb_reg;
            f3_cb_reg  <= f2_cb_reg;
            // The cross term appears twice, hence one shift more than half the width.
            f3_p2_reg  <= (pbfe_pkg::P2_W'(f2_hh_reg) << pbfe_pkg::P_W)
                        + (pbfe_pkg::P2_W'(f2_hl_reg) << (PH_W + 1))
                        + pbfe_pkg::P2_W'(f2_ll_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f4_rsq_reg  <= f3_rsq_reg;
            f4_n_reg    <= f3_n_reg;
            f4_bb_reg   <= f3_bb_reg;
            f4_cb_reg   <= f3_cb_reg;
            f4_p2_reg   <= f3_p2_reg;
            f4_mh_reg   <= f3_p2_reg[pbfe_pkg::P2_W-1:pbfe_pkg::P_W] * pbfe_pkg::LAM_SQ_NUM;
            f4_ml_reg   <= f3_p2_reg[pbfe_pkg::P_W-1:0] * pbfe_pkg::LAM_SQ_NUM;
            f4_r10k_reg <= f3_rsq_reg * pbfe_pkg::LAM_SQ_DEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f5_rsq_reg   <= f4_rsq_reg;
            f5_n_reg     <= f4_n_reg;
            f5_bb_reg    <= f4_bb_reg;
            f5_cb_reg    <= f4_cb_reg;
            f5_p2_reg    <= f4_p2_reg;
            f5_r10k_reg  <= f4_r10k_reg;
            f5_c9801_reg <= (pbfe_pkg::C9801_W'(f4_mh_reg) << pbfe_pkg::P_W)
                          + pbfe_pkg::C9801_W'(f4_ml_reg);
        end
    end

    // Exact tests: rsq > 4*(Nb)^2 is fatal, rsq > 0.9801*(Nb)^2 is clamped.
    assign cmp_fatal_lhs = pbfe_pkg::CMP_W'(f5_rsq_reg) << (48 - F);
    assign cmp_fatal_rhs = pbfe_pkg::CMP_W'(f5_p2_reg) << 2;
    assign cmp_clamp_lhs = pbfe_pkg::CMP_W'(f5_r10k_reg) << (48 - F);
    assign cmp_clamp_rhs = pbfe_pkg::CMP_W'(f5_c9801_reg);

    always_comb begin
        if (cmp_fatal_lhs > cmp_fatal_rhs) begin
            f5_status = pbfe_pkg::ST_FATAL;
        end else if (cmp_clamp_lhs > cmp_clamp_rhs) begin
            f5_status = pbfe_pkg::ST_CLAMP;
        end else begin
            f5_status = pbfe_pkg::ST_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f6_side_reg.zero   <= (f5_rsq_reg == '0);
            f6_side_reg.status <= f5_status;
            f6_side_reg.n      <= f5_n_reg;
            f6_side_reg.bb     <= f5_bb_reg;
            f6_side_reg.cb     <= f5_cb_reg;
            f6_side_reg.p2     <= f5_p2_reg;
            f6_side_reg.rsq    <= f5_rsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root r = floor(sqrt(rsq << FRAC_BITS)), needed by the clamped force.
    // ------------------------------------------------------------------
    localparam int SQN = pbfe_pkg::SQ_RW;

    logic                           sq_v    [0:SQN];
    logic [pbfe_pkg::SQ_AW-1:0]     sq_arg  [0:SQN];
    logic [SQN+1:0]                 sq_rem  [0:SQN];
    logic [SQN-1:0]                 sq_res  [0:SQN];
    logic [SQ_SW-1:0]               sq_side [0:SQN];

    assign sq_v[0]    = f6_v_reg;
    assign sq_arg[0]  = pbfe_pkg::SQ_AW'(f6_side_reg.rsq) << F;
    assign sq_rem[0]  = '0;
    assign sq_res[0]  = '0;
    assign sq_side[0] = f6_side_reg;

    for (genvar gi = 0; gi < SQN; gi++) begin : g_sqrt
        pbfe_sqrt_step #(
            .AW (pbfe_pkg::SQ_AW),
            .RW (SQN),
            .SW (SQ_SW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (sq_v[gi]),
            .in_arg    (sq_arg[gi]),
            .in_rem    (sq_rem[gi]),
            .in_res    (sq_res[gi]),
            .in_side   (sq_side[gi]),
            .out_valid (sq_v[gi+1]),
            .out_arg   (sq_arg[gi+1]),
            .out_rem   (sq_rem[gi+1]),
            .out_res   (sq_res[gi+1]),
            .out_side  (sq_side[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // lam^2 divider: s = floor(rsq * 2^(80-FRAC_BITS) / (Nb)^2), a Q0.32 quotient.
    // For an unclamped stretch the quotient is below 2^32, so the upper part of the
    // numerator starts out below the divisor.
    // ------------------------------------------------------------------
    pbfe_pkg::sq_side_t            sq_out;
    pbfe_pkg::sd_side_t            sd_in;
    logic [pbfe_pkg::SNUM_W-1:0]   s_num;

    assign sq_out       = pbfe_pkg::sq_side_t'(sq_side[SQN]);
    assign s_num        = pbfe_pkg::SNUM_W'(sq_out.rsq) << (80 - F);
    assign sd_in.zero   = sq_out.zero;
    assign sd_in.status = sq_out.status;
    assign sd_in.n      = sq_out.n;
    assign sd_in.bb     = sq_out.bb;
    assign sd_in.cb     = sq_out.cb;
    assign sd_in.r      = sq_res[SQN];

    logic                           sd_v    [0:QW];
    logic [pbfe_pkg::P2_W-1:0]      sd_rem  [0:QW];
    logic [QW-1:0]                  sd_nlo  [0:QW];
    logic [pbfe_pkg::P2_W-1:0]      sd_den  [0:QW];
    logic [QW-1:0]                  sd_q    [0:QW];
    logic [SD_SW-1:0]               sd_side [0:QW];

    assign sd_v[0]    = sq_v[SQN];
    assign sd_rem[0]  = pbfe_pkg::P2_W'(s_num >> QW);
    assign sd_nlo[0]  = s_num[QW-1:0];
    assign sd_den[0]  = sq_out.p2;
    assign sd_q[0]    = '0;
    assign sd_side[0] = sd_in;

    for (genvar gi = 0; gi < QW; gi++) begin : g_sdiv
        pbfe_div_step #(
            .DW (pbfe_pkg::P2_W),
            .SW (SD_SW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (sd_v[gi]),
            .in_rem    (sd_rem[gi]),
            .in_nlo    (sd_nlo[gi]),
            .in_den    (sd_den[gi]),
            .in_q      (sd_q[gi]),
            .in_side   (sd_side[gi]),
            .out_valid (sd_v[gi+1]),
            .out_rem   (sd_rem[gi+1]),
            .out_nlo   (sd_nlo[gi+1]),
            .out_den   (sd_den[gi+1]),
            .out_q     (sd_q[gi+1]),
            .out_side  (sd_side[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Force denominator and numerator.
    // Unclamped: (3 - lam^2) << (FRAC_BITS+40) over (1 - lam^2) * N * b^2.
    // Clamped:   1999701 << (2*FRAC_BITS+16) over 19900 * b * r.
    // ------------------------------------------------------------------
    pbfe_pkg::sd_side_t sd_out;
    logic [QW-1:0]      s_sel;
    logic               sd_clamped;
    logic [pbfe_pkg::D_W-1:0] d_val;

    assign sd_out     = pbfe_pkg::sd_side_t'(sd_side[QW]);
    assign sd_clamped = (sd_out.status != pbfe_pkg::ST_NORMAL);
    assign s_sel      = sd_clamped ? pbfe_pkg::S_CLAMP : sd_q[QW];
    assign d_val      = (pbfe_pkg::D_W'(1) << QW) - pbfe_pkg::D_W'(s_sel);

    localparam int CB_HI_W = pbfe_pkg::CB_W - pbfe_pkg::CB_LO_W;
    localparam int DN_HI_W = pbfe_pkg::DN_W - pbfe_pkg::DN_LO_W;
    localparam int BBH_W   = pbfe_pkg::BB_W / 2;

    logic                         g_v_reg, h_v_reg, i_v_reg, j_v_reg;
    logic                         g_zero_reg, h_zero_reg, i_zero_reg;
    pbfe_pkg::status_t            g_status_reg, h_status_reg, i_status_reg;
    logic [pbfe_pkg::SEG_W-1:0]   g_n_reg, h_n_reg, i_n_reg;
    logic [QW-1:0]                g_s_reg, h_s_reg, i_s_reg;
    logic [pbfe_pkg::T_W-1:0]     g_t_reg, h_t_reg;
    logic [pbfe_pkg::DN_W-1:0]    g_dn_reg;
    logic [pbfe_pkg::BB_W-1:0]    g_bb_reg;
    logic [CB_HI_W+SQN-1:0]       g_crh_reg;
    logic [pbfe_pkg::CB_LO_W+SQN-1:0] g_crl_reg;
    logic [DN_HI_W+BBH_W-1:0]     h_phh_reg, h_phl_reg;
    logic [pbfe_pkg::DN_LO_W+BBH_W-1:0] h_plh_reg, h_pll_reg;
    logic [pbfe_pkg::CR_W-1:0]    h_cr_reg;
    logic [pbfe_pkg::MD_W-1:0]    i_rem_reg, i_den_reg;
    logic [QW-1:0]                i_nlo_reg;
    pbfe_pkg::md_side_t           j_side_reg;
    logic [pbfe_pkg::MD_W-1:0]    j_rem_reg, j_den_reg;
    logic [QW-1:0]                j_nlo_reg;

    logic [pbfe_pkg::MD_W-1:0]    den_u;
    logic [pbfe_pkg::MNUM_W-1:0]  num_u, num_c, num_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
        end else if (ce) begin
            g_v_reg <= sd_v[QW];
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            j_v_reg <= i_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            g_zero_reg   <= sd_out.zero;
            g_status_reg <= sd_out.status;
            g_n_reg      <= sd_out.n;
            g_s_reg      <= s_sel;
            g_t_reg      <= (pbfe_pkg::T_W'(3) << QW) - pbfe_pkg::T_W'(s_sel);
            g_dn_reg     <= d_val * sd_out.n;
            g_bb_reg     <= sd_out.bb;
            g_crh_reg    <= sd_out.cb[pbfe_pkg::CB_W-1:pbfe_pkg::CB_LO_W] * sd_out.r;
            g_crl_reg    <= sd_out.cb[pbfe_pkg::CB_LO_W-1:0] * sd_out.r;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_zero_reg   <= g_zero_reg;
            h_status_reg <= g_status_reg;
            h_n_reg      <= g_n_reg;
            h_s_reg      <= g_s_reg;
            h_t_reg      <= g_t_reg;
            h_phh_reg    <= g_dn_reg[pbfe_pkg::DN_W-1:pbfe_pkg::DN_LO_W]
                          * g_bb_reg[pbfe_pkg::BB_W-1:BBH_W];
            h_phl_reg    <= g_dn_reg[pbfe_pkg::DN_W-1:pbfe_pkg::DN_LO_W]
                          * g_bb_reg[BBH_W-1:0];
            h_plh_reg    <= g_dn_reg[pbfe_pkg::DN_LO_W-1:0]
                          * g_bb_reg[pbfe_pkg::BB_W-1:BBH_W];
            h_pll_reg    <= g_dn_reg[pbfe_pkg::DN_LO_W-1:0] * g_bb_reg[BBH_W-1:0];
            h_cr_reg     <= (pbfe_pkg::CR_W'(g_crh_reg) << pbfe_pkg::CB_LO_W)
                          + pbfe_pkg::CR_W'(g_crl_reg);
        end
    end

    assign den_u = (pbfe_pkg::MD_W'(h_phh_reg) << (pbfe_pkg::DN_LO_W + BBH_W))
                 + (pbfe_pkg::MD_W'(h_phl_reg) << pbfe_pkg::DN_LO_W)
                 + (pbfe_pkg::MD_W'(h_plh_reg) << BBH_W)
                 + pbfe_pkg::MD_W'(h_pll_reg);
    assign num_u = pbfe_pkg::MNUM_W'(h_t_reg) << (F + 40);
    assign num_c = pbfe_pkg::MNUM_W'(pbfe_pkg::CLAMP_NUM) << (2 * F + 16);
    assign num_sel = (h_status_reg != pbfe_pkg::ST_NORMAL) ? num_c : num_u;

    always_ff @(posedge aclk) begin
        if (ce) begin
            i_zero_reg   <= h_zero_reg;
            i_status_reg <= h_status_reg;
            i_n_reg      <= h_n_reg;
            i_s_reg      <= h_s_reg;
            i_rem_reg    <= pbfe_pkg::MD_W'(num_sel >> QW);
            i_nlo_reg    <= num_sel[QW-1:0];
            i_den_reg    <= (h_status_reg != pbfe_pkg::ST_NORMAL)
                          ? pbfe_pkg::MD_W'(h_cr_reg) : den_u;
        end
    end

    // A quotient of 2^32 or more, or a zero divisor, saturates the force.
    always_ff @(posedge aclk) begin
        if (ce) begin
            j_side_reg.zero   <= i_zero_reg;
            j_side_reg.status <= i_status_reg;
            j_side_reg.n      <= i_n_reg;
            j_side_reg.s      <= i_s_reg;
            j_side_reg.ovf    <= (i_rem_reg >= i_den_reg);
            j_rem_reg         <= i_rem_reg;
            j_nlo_reg         <= i_nlo_reg;
            j_den_reg         <= i_den_reg;
        end
    end

    // ------------------------------------------------------------------
    // Force divider.
    // ------------------------------------------------------------------
    logic                           md_v    [0:QW];
    logic [pbfe_pkg::MD_W-1:0]      md_rem  [0:QW];
    logic [QW-1:0]                  md_nlo  [0:QW];
    logic [pbfe_pkg::MD_W-1:0]      md_den  [0:QW];
    logic [QW-1:0]                  md_q    [0:QW];
    logic [MD_SW-1:0]               md_side [0:QW];

    assign md_v[0]    = j_v_reg;
    assign md_rem[0]  = j_rem_reg;
    assign md_nlo[0]  = j_nlo_reg;
    assign md_den[0]  = j_den_reg;
    assign md_q[0]    = '0;
    assign md_side[0] = j_side_reg;

    for (genvar gi = 0; gi < QW; gi++) begin : g_mdiv
        pbfe_div_step #(
            .DW (pbfe_pkg::MD_W),
            .SW (MD_SW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (md_v[gi]),
            .in_rem    (md_rem[gi]),
            .in_nlo    (md_nlo[gi]),
            .in_den    (md_den[gi]),
            .in_q      (md_q[gi]),
            .in_side   (md_side[gi]),
            .out_valid (md_v[gi+1]),
            .out_rem   (md_rem[gi+1]),
            .out_nlo   (md_nlo[gi+1]),
            .out_den   (md_den[gi+1]),
            .out_q     (md_q[gi+1]),
            .out_side  (md_side[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Saturate the force magnitude, and normalize x = 1 - lam^2 for the logarithm:
    // x = y * 2^-k with y in [1,2) as a Q1.32 mantissa.
    // ------------------------------------------------------------------
    localparam int Y_W = pbfe_pkg::Y_W;
    localparam int K_W = pbfe_pkg::K_W;

    pbfe_pkg::md_side_t md_out;
    logic [QW-1:0]      mag;
    logic [Y_W-1:0]     lg_x;
    logic [K_W-1:0]     lz_k;
    logic               k_v_reg;
    pbfe_pkg::lg_side_t k_side_reg;
    logic [Y_W-1:0]     k_y_reg;

    assign md_out = pbfe_pkg::md_side_t'(md_side[QW]);
    assign mag    = (md_out.ovf || md_q[QW] > (QW'(1) << (QW - 1)))
                  ? (QW'(1) << (QW - 1)) : md_q[QW];
    assign lg_x   = (Y_W'(1) << QW) - Y_W'(md_out.s);

    always_comb begin
        lz_k = '0;
        for (int i = 0; i < Y_W; i++) begin
            if (lg_x[i]) begin
                lz_k = K_W'(Y_W - 1 - i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_v_reg <= 1'b0;
        end else if (ce) begin
            k_v_reg <= md_v[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k_side_reg.zero   <= md_out.zero;
            k_side_reg.status <= md_out.status;
            k_side_reg.n      <= md_out.n;
            k_side_reg.s      <= md_out.s;
            k_side_reg.frc    <= pbfe_pkg::FORCE_W'(QW'(0) - mag);
            k_side_reg.k      <= lz_k;
            k_y_reg           <= lg_x << lz_k;
        end
    end

    // ------------------------------------------------------------------
    // log2 of the mantissa, one fraction bit per squaring stage.
    // ------------------------------------------------------------------
    logic               lg_v    [0:QW];
    logic [Y_W-1:0]     lg_y    [0:QW];
    logic [QW-1:0]      lg_frac [0:QW];
    logic [LG_SW-1:0]   lg_side [0:QW];

    assign lg_v[0]    = k_v_reg;
    assign lg_y[0]    = k_y_reg;
    assign lg_frac[0] = '0;
    assign lg_side[0] = k_side_reg;

    for (genvar gi = 0; gi < QW; gi++) begin : g_log
        pbfe_log_step #(
            .SW (LG_SW)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (lg_v[gi]),
            .in_y      (lg_y[gi]),
            .in_frac   (lg_frac[gi]),
            .in_side   (lg_side[gi]),
            .out_valid (lg_v[gi+1]),
            .out_y     (lg_y[gi+1]),
            .out_frac  (lg_frac[gi+1]),
            .out_side  (lg_side[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Energy tail: -ln(1-lam^2) = (k - log2 y) * ln2, plus lam^2/2, times N.
    // ------------------------------------------------------------------
    localparam int LNA_W  = pbfe_pkg::LNA_W;
    localparam int H_W    = pbfe_pkg::H_W;
    localparam int H_LO_W = pbfe_pkg::H_LO_W;
    localparam int EN_W   = pbfe_pkg::EN_W;
    localparam int SEG_W  = pbfe_pkg::SEG_W;

    pbfe_pkg::lg_side_t lg_out;

    assign lg_out = pbfe_pkg::lg_side_t'(lg_side[QW]);

    logic                        l_v_reg, p_v_reg, q_v_reg, r_v_reg, t_v_reg;
    logic                        l_zero_reg, p_zero_reg, q_zero_reg, r_zero_reg, t_zero_reg;
    pbfe_pkg::status_t           l_status_reg, p_status_reg, q_status_reg, r_status_reg;
    pbfe_pkg::status_t           t_status_reg;
    logic [SEG_W-1:0]            l_n_reg, p_n_reg, q_n_reg, r_n_reg;
    logic [QW-1:0]               l_s_reg, p_s_reg, q_s_reg;
    logic [pbfe_pkg::FORCE_W-1:0] l_frc_reg, p_frc_reg, q_frc_reg, r_frc_reg, t_frc_reg;
    logic [LNA_W-1:0]            l_a_reg;
    logic [2*QW-1:0]             p_plo_reg;
    logic [K_W+QW-1:0]           p_phi_reg;
    logic [H_W-1:0]              q_nl_reg, r_h_reg;
    logic [SEG_W+H_W-H_LO_W-1:0] t_eh_reg;
    logic [SEG_W+H_LO_W-1:0]     t_el_reg;

    logic [EN_W-1:0]             e_full;
    logic [EN_W-1:0]             e_shift;
    logic [pbfe_pkg::ENERGY_W-1:0] e_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
            t_v_reg <= 1'b0;
        end else if (ce) begin
            l_v_reg <= lg_v[QW];
            p_v_reg <= l_v_reg;
            q_v_reg <= p_v_reg;
            r_v_reg <= q_v_reg;
            t_v_reg <= r_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            l_zero_reg   <= lg_out.zero;
            l_status_reg <= lg_out.status;
            l_n_reg      <= lg_out.n;
            l_s_reg      <= lg_out.s;
            l_frc_reg    <= lg_out.frc;
            l_a_reg      <= (LNA_W'(lg_out.k) << QW) - LNA_W'(lg_frac[QW]);

            p_zero_reg   <= l_zero_reg;
            p_status_reg <= l_status_reg;
            p_n_reg      <= l_n_reg;
            p_s_reg      <= l_s_reg;
            p_frc_reg    <= l_frc_reg;
            p_plo_reg    <= l_a_reg[QW-1:0] * pbfe_pkg::LN2_Q32;
            p_phi_reg    <= l_a_reg[LNA_W-1:QW] * pbfe_pkg::LN2_Q32;

            q_zero_reg   <= p_zero_reg;
            q_status_reg <= p_status_reg;
            q_n_reg      <= p_n_reg;
            q_s_reg      <= p_s_reg;
            q_frc_reg    <= p_frc_reg;
            q_nl_reg     <= H_W'(p_phi_reg) + H_W'(p_plo_reg[2*QW-1:QW]);

            r_zero_reg   <= q_zero_reg;
            r_status_reg <= q_status_reg;
            r_n_reg      <= q_n_reg;
            r_frc_reg    <= q_frc_reg;
            r_h_reg      <= H_W'(q_s_reg >> 1) + q_nl_reg;

            t_zero_reg   <= r_zero_reg;
            t_status_reg <= r_status_reg;
            t_frc_reg    <= r_frc_reg;
            t_eh_reg     <= r_n_reg * r_h_reg[H_W-1:H_LO_W];
            t_el_reg     <= r_n_reg * r_h_reg[H_LO_W-1:0];
        end
    end

    assign e_full  = (EN_W'(t_eh_reg) << H_LO_W) + EN_W'(t_el_reg);
    assign e_shift = e_full >> (40 - F);
    assign e_sat   = (|e_shift[EN_W-1:pbfe_pkg::ENERGY_W]) ? '1
                   : e_shift[pbfe_pkg::ENERGY_W-1:0];

    // Output register. A zero length forces every field to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= t_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_force_over_r <= t_zero_reg ? '0 : $signed(t_frc_reg);
            m_energy       <= t_zero_reg ? '0 : e_sat;
            m_status       <= t_zero_reg ? pbfe_pkg::ST_NORMAL : t_status_reg;
        end
    end

endmodule
